FILE: hdl/qbts_pkg.sv
`default_nettype none

package qbts_pkg;

  // sizing of the batch
  localparam int TEXTURE_SLOTS = 32;
  localparam int MAX_QUADS     = 4096;
  localparam int QUAD_INDICES  = 6;
  localparam int MAX_INDICES   = MAX_QUADS * QUAD_INDICES;

  // derived widths
  localparam int SLOT_AW = $clog2(TEXTURE_SLOTS);
  localparam int CNT_W   = $clog2(TEXTURE_SLOTS + 1);
  localparam int IDX_W   = $clog2(MAX_INDICES + 1);

  // fixed field widths
  localparam int COORD_W     = 32;
  localparam int ID_W        = 32;
  localparam int COLOR_W     = 8;
  localparam int SLOT_PORT_W = 5;

  typedef enum logic [1:0] {
    OP_COLOR = 2'd0,
    OP_TEX   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_BIND   = 2'd1,
    KIND_DRAW   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIND,
    ST_DRAW,
    ST_SEARCH,
    ST_VTX
  } state_t;

  // access to the slot table memory
  typedef struct packed {
    logic               rd_en;
    logic [SLOT_AW-1:0] rd_addr;
    logic               wr_en;
    logic [SLOT_AW-1:0] wr_addr;
    logic [ID_W-1:0]    wr_data;
  } ram_req_t;

  // one result item
  typedef struct packed {
    kind_t                     kind;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic [COLOR_W-1:0]        out_red;
    logic [COLOR_W-1:0]        out_green;
    logic [COLOR_W-1:0]        out_blue;
    logic [COLOR_W-1:0]        out_alpha;
    logic                      tex_u;
    logic                      tex_v;
    logic [SLOT_PORT_W-1:0]    tex_slot;
    logic [ID_W-1:0]           payload;
    logic                      last;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/qbts_if.sv
`default_nettype none

// draw command channel
interface qbts_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] size_x;
  logic signed [31:0] size_y;
  logic [7:0]         color_r;
  logic [7:0]         color_g;
  logic [7:0]         color_b;
  logic [7:0]         color_a;
  logic [31:0]        texture_id;

  modport source (output valid, opcode, pos_x, pos_y, size_x, size_y,
                  color_r, color_g, color_b, color_a, texture_id,
                  input ready);
  modport sink (input valid, opcode, pos_x, pos_y, size_x, size_y,
                color_r, color_g, color_b, color_a, texture_id,
                output ready);
endinterface

// result channel
interface qbts_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;
  logic [7:0]         out_alpha;
  logic               tex_u;
  logic               tex_v;
  logic [4:0]         tex_slot;
  logic [31:0]        payload;
  logic               last;

  modport source (output valid, kind, vertex_x, vertex_y, out_red, out_green,
                  out_blue, out_alpha, tex_u, tex_v, tex_slot, payload, last,
                  input ready);
  modport sink (input valid, kind, vertex_x, vertex_y, out_red, out_green,
                out_blue, out_alpha, tex_u, tex_v, tex_slot, payload, last,
                output ready);
endinterface

// configuration write channel
interface qbts_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/qbts_slot_ram.sv
`default_nettype none

module qbts_slot_ram
  import qbts_pkg::*;
(
  input  wire logic            clk,
  input  wire ram_req_t        req,
  output      logic [ID_W-1:0] rd_data_r
);

  logic [ID_W-1:0] mem [TEXTURE_SLOTS];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/qbts_corner.sv
`default_nettype none

module qbts_corner
  import qbts_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      load,
  input  wire logic signed [COORD_W-1:0] pos_x,
  input  wire logic signed [COORD_W-1:0] pos_y,
  input  wire logic signed [COORD_W-1:0] size_x,
  input  wire logic signed [COORD_W-1:0] size_y,
  input  wire logic [1:0]                corner,
  output      logic signed [COORD_W-1:0] vertex_x,
  output      logic signed [COORD_W-1:0] vertex_y
);

  logic signed [COORD_W-1:0] x0_r, y0_r, x1_r, y1_r;

  // add with clamp to the signed range
  function automatic logic signed [COORD_W-1:0] sat_add(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (s[COORD_W] != s[COORD_W-1]) begin
      sat_add = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      sat_add = s[COORD_W-1:0];
    end
  endfunction

  // corner coordinates captured with the command
  always_ff @(posedge clk) begin
    if (load) begin
      x0_r <= pos_x;
      y0_r <= pos_y;
      x1_r <= sat_add(pos_x, size_x);
      y1_r <= sat_add(pos_y, size_y);
    end
  end

  // corner walk: top left, top right, bottom right, bottom left
  assign vertex_x = (corner == 2'd1 || corner == 2'd2) ? x1_r : x0_r;
  assign vertex_y = corner[1] ? y1_r : y0_r;

endmodule

`default_nettype wire

FILE: hdl/quad_batcher_texture_slots_core.sv
// Sprite quad batcher with a texture slot table.
// in_cmd carries commands: colored quad, textured quad, flush or no-op; a
// command transfers when valid and ready are both high. out_res carries the
// results: four corner vertices per quad, one bind per used texture slot and
// a draw with the index count per flush; last marks the final result of a
// command. cfg_wr writes the texture id bound on slot zero and is always ready.
// After a quad the next command transfers during its last vertex. A textured
// quad first compares its texture id with the slots in use in the slot table
// memory, from slot one upward, and claims a new slot on a miss. A flush
// emits one bind per used slot and then the draw; after a requested flush the
// next command can transfer in the cycle after the draw. An automatic flush
// comes before the vertices. A command's first result is formed in the state
// after the transfer, or after the slot search for a textured quad, and is
// then held in the output register.
// Reset clears the counters (one slot in use, no indices) and the register;
// the slot table needs no clearing pass since only claimed slots are compared or bound.
// A single output register holds each result; when the receiver stalls the
// bind, draw and vertex steps wait, but an idle core still takes a command.

`default_nettype none

module quad_batcher_texture_slots_core
  import qbts_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  qbts_cmd_if.sink   in_cmd,
  qbts_res_if.source out_res,
  qbts_cfg_if.sink   cfg_wr
);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt, idx_inc;
  logic [1:0]         vtx_r, vtx_nxt;
  logic [SLOT_AW-1:0] slot_r, slot_nxt;
  logic               final_r, final_nxt;
  logic [CNT_W-1:0]   slot_count_r, slot_count_nxt;
  logic [IDX_W-1:0]   index_count_r, index_count_nxt, idx_eff;
  logic [ID_W-1:0]    white_id_r;

  op_t                op_r;
  logic [ID_W-1:0]    tex_id_r;
  logic [COLOR_W-1:0] red_r, green_r, blue_r, alpha_r;

  logic out_valid_r;
  res_t out_r;
  res_t res;
  logic emit;
  logic out_free;
  logic in_ready;
  logic in_fire;
  logic need_flush;
  op_t  in_op;

  ram_req_t                  ram_req;
  logic [ID_W-1:0]           rd_data_r;
  logic signed [COORD_W-1:0] corner_x, corner_y;

  // slot table memory
  qbts_slot_ram u_slot_ram (
    .clk       (clk),
    .req       (ram_req),
    .rd_data_r (rd_data_r)
  );

  // saturated corner coordinates
  qbts_corner u_corner (
    .clk      (clk),
    .load     (in_fire),
    .pos_x    (in_cmd.pos_x),
    .pos_y    (in_cmd.pos_y),
    .size_x   (in_cmd.size_x),
    .size_y   (in_cmd.size_y),
    .corner   (vtx_r),
    .vertex_x (corner_x),
    .vertex_y (corner_y)
  );

  // handshakes
  assign out_free = !out_valid_r || out_res.ready;
  assign in_ready = (state_r == ST_IDLE) ||
                    (state_r == ST_VTX && vtx_r == 2'd3 && out_free);
  assign in_fire  = in_cmd.valid && in_ready;
  assign in_cmd.ready = in_ready;
  assign cfg_wr.ready = 1'b1;
  assign in_op    = op_t'(in_cmd.opcode);
  assign idx_inc  = idx_r + CNT_W'(1);

  // index count as seen by a command taken during the last vertex
  assign idx_eff = (state_r == ST_VTX) ? index_count_r + IDX_W'(QUAD_INDICES)
                                       : index_count_r;
  assign need_flush = (idx_eff >= IDX_W'(MAX_INDICES)) ||
                      (in_op == OP_TEX && slot_count_r >= CNT_W'(TEXTURE_SLOTS));

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      idx_r         <= '0;
      vtx_r         <= '0;
      slot_r        <= '0;
      final_r       <= 1'b0;
      slot_count_r  <= CNT_W'(1);
      index_count_r <= '0;
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      vtx_r         <= vtx_nxt;
      slot_r        <= slot_nxt;
      final_r       <= final_nxt;
      slot_count_r  <= slot_count_nxt;
      index_count_r <= index_count_nxt;
    end
  end

  // command fields held for the duration of the command
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_op;
      tex_id_r <= in_cmd.texture_id;
      if (in_op == OP_TEX) begin
        red_r   <= '1;
        green_r <= '1;
        blue_r  <= '1;
        alpha_r <= '1;
      end else begin
        red_r   <= in_cmd.color_r;
        green_r <= in_cmd.color_g;
        blue_r  <= in_cmd.color_b;
        alpha_r <= in_cmd.color_a;
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_id_r <= '0;
    end else if (cfg_wr.valid) begin
      white_id_r <= cfg_wr.data;
    end
  end

  // next state, memory access and result formation
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    vtx_nxt         = vtx_r;
    slot_nxt        = slot_r;
    final_nxt       = final_r;
    slot_count_nxt  = slot_count_r;
    index_count_nxt = index_count_r;
    ram_req         = '0;
    emit            = 1'b0;
    res             = '0;

    unique case (state_r)
      ST_IDLE: begin
      end

      // one bind per used slot, slot zero from the register
      ST_BIND: begin
        if (out_free) begin
          emit         = 1'b1;
          res.kind     = KIND_BIND;
          res.tex_slot = SLOT_PORT_W'(idx_r);
          res.payload  = (idx_r == '0) ? white_id_r : rd_data_r;
          if (idx_r == slot_count_r - CNT_W'(1)) begin
            state_nxt = ST_DRAW;
          end else begin
            idx_nxt         = idx_inc;
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = idx_inc[SLOT_AW-1:0];
          end
        end
      end

      // draw, then start a new batch
      ST_DRAW: begin
        if (out_free) begin
          emit            = 1'b1;
          res.kind        = KIND_DRAW;
          res.payload     = ID_W'(index_count_r);
          res.last        = final_r;
          index_count_nxt = '0;
          slot_count_nxt  = CNT_W'(1);
          if (final_r) begin
            state_nxt = ST_IDLE;
          end else if (op_r == OP_TEX) begin
            state_nxt       = ST_SEARCH;
            idx_nxt         = CNT_W'(1);
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = SLOT_AW'(1);
          end else begin
            state_nxt = ST_VTX;
            vtx_nxt   = '0;
            slot_nxt  = '0;
          end
        end
      end

      // compare one slot per cycle, claim the next free one on a miss
      ST_SEARCH: begin
        if (idx_r >= slot_count_r) begin
          state_nxt = ST_VTX;
          vtx_nxt   = '0;
          if (slot_count_r < CNT_W'(TEXTURE_SLOTS)) begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = slot_count_r[SLOT_AW-1:0];
            ram_req.wr_data = tex_id_r;
            slot_nxt        = slot_count_r[SLOT_AW-1:0];
            slot_count_nxt  = slot_count_r + CNT_W'(1);
          end else begin
            slot_nxt = '0;
          end
        end else if (rd_data_r == tex_id_r) begin
          state_nxt = ST_VTX;
          vtx_nxt   = '0;
          slot_nxt  = idx_r[SLOT_AW-1:0];
        end else begin
          idx_nxt         = idx_inc;
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = idx_inc[SLOT_AW-1:0];
        end
      end

      // four corners of the quad
      ST_VTX: begin
        if (out_free) begin
          emit          = 1'b1;
          res.kind      = KIND_VERTEX;
          res.vertex_x  = corner_x;
          res.vertex_y  = corner_y;
          res.out_red   = red_r;
          res.out_green = green_r;
          res.out_blue  = blue_r;
          res.out_alpha = alpha_r;
          res.tex_u     = (vtx_r == 2'd1) || (vtx_r == 2'd2);
          res.tex_v     = vtx_r[1];
          res.tex_slot  = SLOT_PORT_W'(slot_r);
          res.last      = (vtx_r == 2'd3);
          if (vtx_r == 2'd3) begin
            index_count_nxt = index_count_r + IDX_W'(QUAD_INDICES);
            state_nxt       = ST_IDLE;
          end else begin
            vtx_nxt = vtx_r + 2'd1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // command transfer picks the first step of the new command
    if (in_fire) begin
      unique case (in_op) inside
        OP_NOP: begin
          state_nxt = ST_IDLE;
        end
        OP_FLUSH: begin
          state_nxt = ST_BIND;
          idx_nxt   = '0;
          final_nxt = 1'b1;
        end
        OP_COLOR, OP_TEX: begin
          final_nxt = 1'b0;
          if (need_flush) begin
            state_nxt = ST_BIND;
            idx_nxt   = '0;
          end else if (in_op == OP_TEX) begin
            state_nxt       = ST_SEARCH;
            idx_nxt         = CNT_W'(1);
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = SLOT_AW'(1);
          end else begin
            state_nxt = ST_VTX;
            vtx_nxt   = '0;
            slot_nxt  = '0;
          end
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.kind      = out_r.kind;
  assign out_res.vertex_x  = out_r.vertex_x;
  assign out_res.vertex_y  = out_r.vertex_y;
  assign out_res.out_red   = out_r.out_red;
  assign out_res.out_green = out_r.out_green;
  assign out_res.out_blue  = out_r.out_blue;
  assign out_res.out_alpha = out_r.out_alpha;
  assign out_res.tex_u     = out_r.tex_u;
  assign out_res.tex_v     = out_r.tex_v;
  assign out_res.tex_slot  = out_r.tex_slot;
  assign out_res.payload   = out_r.payload;
  assign out_res.last      = out_r.last;

  // slot count stays within the table
  a_slot_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_count_r >= CNT_W'(1) && slot_count_r <= CNT_W'(TEXTURE_SLOTS))
    else $error("slot count out of range");

  // a draw starts a fresh batch
  a_draw_resets_batch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAW && out_free) |=>
      (index_count_r == '0 && slot_count_r == CNT_W'(1)))
    else $error("batch not reset after draw");

  // index count never passes the flush limit
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    index_count_r <= IDX_W'(MAX_INDICES))
    else $error("index count above limit");

  // a command never ends on a bind
  a_last_not_bind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.last) |-> (out_res.kind != KIND_BIND))
    else $error("last result is a bind");

endmodule

`default_nettype wire
